// ===== design/cinq_pkg.sv =====
// shared types and constants of the contour inward normal quad block
package cinq_pkg;

	localparam int NIN_W  = 34;
	localparam int NOUT_W = 32;
	localparam int IDX_W  = 10;
	localparam int FLD_W  = 24;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_EMIT   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// per beat of the quad, bit k for beat k
	localparam logic [5:0] BEAT_USE_J = 6'b010110;
	localparam logic [5:0] BEAT_RAMP  = 6'b110100;

	typedef struct packed {
		logic                    start;
		logic                    frac14;
		logic signed [NIN_W-1:0] a;
		logic signed [NIN_W-1:0] b;
	} norm_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [NOUT_W-1:0] oa;
		logic signed [NOUT_W-1:0] ob;
	} norm_rsp_t;

endpackage

// ===== design/cinq_ram.sv =====
// generic single write, single read memory with registered read data
module cinq_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/cinq_norm.sv =====
// bit-serial vector normaliser: range scaling, integer square root, two divisions
module cinq_norm import cinq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  norm_req_t req,
	output norm_rsp_t rsp
);

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQA   = 3'd2;
	localparam logic [2:0] N_SQB   = 3'd3;
	localparam logic [2:0] N_SQRT  = 3'd4;
	localparam logic [2:0] N_DINIT = 3'd5;
	localparam logic [2:0] N_DIV   = 3'd6;

	localparam logic [NIN_W-1:0] MX_LO = NIN_W'(1) << 28;
	localparam logic [NIN_W-1:0] MX_HI = NIN_W'(1) << 29;

	logic [2:0]        st_q;
	logic [NIN_W-1:0]  ma_q, mb_q;
	logic              neg_a_q, neg_b_q, f14_q, sel_b_q;
	logic [59:0]       s_q, r_q, bit_q, num_q;
	logic [29:0]       rem_q;
	logic [5:0]        cnt_q;
	logic [NOUT_W-1:0] qa_q;
	logic              done_q;
	logic signed [NOUT_W-1:0] oa_q, ob_q;

	logic [NIN_W-1:0] mag_a, mag_b, mx;
	logic [28:0]      m29;
	logic [57:0]      sq;
	logic [59:0]      root_t, one, quo, quo_c;
	logic [30:0]      rem_next;
	logic             ge;

	assign mag_a = req.a[NIN_W-1] ? NIN_W'(-req.a) : NIN_W'(req.a);
	assign mag_b = req.b[NIN_W-1] ? NIN_W'(-req.b) : NIN_W'(req.b);
	assign mx    = (ma_q > mb_q) ? ma_q : mb_q;
	assign m29   = (st_q == N_SQA) ? ma_q[28:0] : mb_q[28:0];
	assign sq    = m29 * m29;
	assign root_t = r_q + bit_q;
	assign one   = f14_q ? (60'(1) << 14) : (60'(1) << 30);
	assign rem_next = {rem_q, num_q[59]};
	assign ge    = rem_next >= {1'b0, r_q[29:0]};
	assign quo   = {num_q[58:0], ge};
	assign quo_c = (quo > one) ? one : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= N_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				N_IDLE: begin
					if (req.start) begin
						st_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (mx >= MX_LO && mx < MX_HI) begin
						st_q <= N_SQA;
					end
				end
				N_SQA:   st_q <= N_SQB;
				N_SQB:   st_q <= N_SQRT;
				N_SQRT: begin
					if (cnt_q == 6'd29) begin
						st_q <= N_DINIT;
					end
				end
				N_DINIT: st_q <= N_DIV;
				N_DIV: begin
					if (cnt_q == 6'd59) begin
						if (!sel_b_q) begin
							st_q <= N_DINIT;
						end else begin
							st_q   <= N_IDLE;
							done_q <= 1'b1;
						end
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				ma_q    <= mag_a;
				mb_q    <= mag_b;
				neg_a_q <= req.a[NIN_W-1];
				neg_b_q <= req.b[NIN_W-1];
				f14_q   <= req.frac14;
				sel_b_q <= 1'b0;
			end
			N_SHIFT: begin
				if (mx < MX_LO) begin
					ma_q <= ma_q << 1;
					mb_q <= mb_q << 1;
				end else if (mx >= MX_HI) begin
					ma_q <= ma_q >> 1;
					mb_q <= mb_q >> 1;
				end
			end
			N_SQA: s_q <= 60'(sq);
			N_SQB: begin
				s_q   <= s_q + 60'(sq);
				r_q   <= '0;
				bit_q <= 60'(1) << 58;
				cnt_q <= '0;
			end
			N_SQRT: begin
				if (s_q >= root_t) begin
					s_q <= s_q - root_t;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 6'd1;
			end
			N_DINIT: begin
				num_q <= ((60'(sel_b_q ? mb_q : ma_q)) << (f14_q ? 14 : 30)) + (r_q >> 1);
				rem_q <= '0;
				cnt_q <= '0;
			end
			N_DIV: begin
				num_q <= quo;
				rem_q <= ge ? 30'(rem_next - {1'b0, r_q[29:0]}) : rem_next[29:0];
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd59) begin
					if (!sel_b_q) begin
						qa_q    <= NOUT_W'(quo_c);
						sel_b_q <= 1'b1;
					end else begin
						oa_q <= neg_a_q ? -$signed(qa_q) : $signed(qa_q);
						ob_q <= neg_b_q ? -$signed(NOUT_W'(quo_c)) : $signed(NOUT_W'(quo_c));
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.oa   = oa_q;
	assign rsp.ob   = ob_q;

endmodule

// ===== design/contour_inward_normal_quads.sv =====
// top level: contour store, winding sum and inward normal quad emitter
//
// A command is taken when start is high and busy is low. An append of the
// first point of a contour, a clear, a full-store append or a refused emit
// leaves busy low; an append of any later point forms two cross products
// through one multiplier, and an emit refused on its keep bit reads that
// point first. An accepted emit reads four points from the point memory,
// forms the winding sum, then runs the edge and vertex normalisations that
// are not skipped through one bit-serial normaliser, each with a square
// root and two divisions, before its six vertices leave on consecutive
// cycles, each marked by vert_valid for one cycle. The receiver cannot
// stall: vertices are not held back and must be taken as they appear.
module contour_inward_normal_quads import cinq_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic signed [FLD_W-1:0] point_x,
	input  logic signed [FLD_W-1:0] point_y,
	input  logic                    keep_edge,
	input  logic [IDX_W-1:0]        edge_index,
	output logic                    vert_valid,
	output logic signed [FLD_W-1:0] vert_x,
	output logic signed [FLD_W-1:0] vert_y,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic                    ramp,
	output logic                    last_vertex
);

	localparam int CB  = COORD_BITS;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int EXT = (CB > FLD_W) ? CB : FLD_W;
	localparam int IW  = (CW > IDX_W) ? CW : IDX_W;
	localparam int RW  = 2 * CB + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_A1   = 4'd1;
	localparam logic [3:0] S_A2   = 4'd2;
	localparam logic [3:0] S_A3   = 4'd3;
	localparam logic [3:0] S_R0   = 4'd4;
	localparam logic [3:0] S_R1   = 4'd5;
	localparam logic [3:0] S_R2   = 4'd6;
	localparam logic [3:0] S_R3   = 4'd7;
	localparam logic [3:0] S_R4   = 4'd8;
	localparam logic [3:0] S_W1   = 4'd9;
	localparam logic [3:0] S_W2   = 4'd10;
	localparam logic [3:0] S_NGO  = 4'd11;
	localparam logic [3:0] S_NWT  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	// normaliser jobs: the edge jobs first, then the vertex jobs
	localparam logic [2:0] JOB_E0 = 3'd0;
	localparam logic [2:0] JOB_E1 = 3'd1;
	localparam logic [2:0] JOB_E2 = 3'd2;
	localparam logic [2:0] JOB_VI = 3'd3;
	localparam logic [2:0] JOB_VJ = 3'd4;

	logic [3:0]  st_q;
	logic [CW-1:0] count_q;
	logic [63:0] area_q, tot_q;
	logic [AW-1:0] i_q;
	logic [2:0]  job_q, beat_q;

	logic signed [CB-1:0] first_x_q, first_y_q, last_x_q, last_y_q, cur_x_q, cur_y_q;
	logic signed [CB-1:0] pm_x_q, pm_y_q, pi_x_q, pi_y_q, pj_x_q, pj_y_q, pk_x_q, pk_y_q;
	logic signed [NOUT_W-1:0] ex_q [3];
	logic signed [NOUT_W-1:0] ey_q [3];
	logic [2:0]  ev_q;
	logic signed [15:0] nxi_q, nyi_q, nxj_q, nyj_q;

	logic signed [CB-1:0]   mul_a, mul_b;
	logic signed [2*CB-1:0] mul_q;

	logic accept;
	logic [CB-1:0] in_x, in_y;
	logic [IW-1:0] idx_ext, cnt_ext;
	logic emit_ok;
	logic [AW-1:0] nm1, im1, jdx, kdx, raddr;
	logic          ram_we;
	logic [RW-1:0] rdata;
	logic signed [CB-1:0] rd_x, rd_y;
	logic          rd_keep;

	logic signed [CB-1:0]  fr_x, fr_y, to_x, to_y;
	logic signed [CB:0]    dx, dy;
	logic                  edge_zero;
	logic signed [NIN_W-1:0] in_nx, in_ny, out_nx, out_ny, sx, sy;
	logic                  in_v, out_v, sx_z, sy_z, tiny;
	logic                  is_vertex;
	logic                  skip_job;
	logic signed [EXT-1:0] ox_ext, oy_ext;
	logic                  use_j;

	norm_req_t nreq;
	norm_rsp_t nrsp;

	assign busy   = (st_q != S_IDLE);
	assign accept = start && !busy;

	// coordinates are the low COORD_BITS bits of the zero-extended field
	assign in_x = CB'(EXT'($unsigned(point_x)));
	assign in_y = CB'(EXT'($unsigned(point_y)));

	assign idx_ext = IW'(edge_index);
	assign cnt_ext = IW'(count_q);
	assign emit_ok = (count_q >= CW'(3)) && (idx_ext < cnt_ext);

	// neighbour indices, wrapping round the closed contour
	assign nm1 = AW'(count_q - CW'(1));
	assign im1 = (i_q == '0) ? nm1 : AW'(i_q - AW'(1));
	assign jdx = (i_q == nm1) ? '0 : AW'(i_q + AW'(1));
	assign kdx = (jdx == nm1) ? '0 : AW'(jdx + AW'(1));

	always_comb begin
		case (st_q)
			S_R1:    raddr = im1;
			S_R2:    raddr = jdx;
			S_R3:    raddr = kdx;
			default: raddr = i_q;
		endcase
	end

	assign ram_we = accept && (mode == MODE_APPEND) && (count_q < CW'(MAX_POINTS));

	cinq_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({keep_edge, in_y, in_x}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_x    = rdata[CB-1:0];
	assign rd_y    = rdata[2*CB-1:CB];
	assign rd_keep = rdata[2*CB];

	// shared multiplier for the cross products
	always_comb begin
		case (st_q)
			S_A1:    begin mul_a = last_x_q;  mul_b = cur_y_q;   end
			S_A2:    begin mul_a = cur_x_q;   mul_b = last_y_q;  end
			S_R4:    begin mul_a = last_x_q;  mul_b = first_y_q; end
			S_W1:    begin mul_a = first_x_q; mul_b = last_y_q;  end
			default: begin mul_a = last_x_q;  mul_b = cur_y_q;   end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// edge and vertex operands for the current job
	always_comb begin
		case (job_q)
			JOB_E0:  begin fr_x = pm_x_q; fr_y = pm_y_q; to_x = pi_x_q; to_y = pi_y_q; end
			JOB_E1:  begin fr_x = pi_x_q; fr_y = pi_y_q; to_x = pj_x_q; to_y = pj_y_q; end
			default: begin fr_x = pj_x_q; fr_y = pj_y_q; to_x = pk_x_q; to_y = pk_y_q; end
		endcase
		if (job_q == JOB_VI) begin
			in_nx = NIN_W'(ex_q[0]); in_ny = NIN_W'(ey_q[0]); in_v = ev_q[0];
			out_nx = NIN_W'(ex_q[1]); out_ny = NIN_W'(ey_q[1]); out_v = ev_q[1];
		end else begin
			in_nx = NIN_W'(ex_q[1]); in_ny = NIN_W'(ey_q[1]); in_v = ev_q[1];
			out_nx = NIN_W'(ex_q[2]); out_ny = NIN_W'(ey_q[2]); out_v = ev_q[2];
		end
	end

	assign dx = (CB+1)'(to_x) - (CB+1)'(fr_x);
	assign dy = (CB+1)'(to_y) - (CB+1)'(fr_y);
	assign edge_zero = (dx == '0) && (dy == '0);

	// both edges valid: sum; one valid: that one; none: zero
	assign sx = (in_v && out_v) ? (in_nx + out_nx) : (out_v ? out_nx : in_nx);
	assign sy = (in_v && out_v) ? (in_ny + out_ny) : (out_v ? out_ny : in_ny);
	assign sx_z = (sx == '0);
	assign sy_z = (sy == '0);
	// squared length below two
	assign tiny = (sx_z || sy_z)
		&& (sx_z || sx == NIN_W'(1) || sx == -NIN_W'(1))
		&& (sy_z || sy == NIN_W'(1) || sy == -NIN_W'(1));

	assign is_vertex = (job_q == JOB_VI) || (job_q == JOB_VJ);
	assign skip_job  = is_vertex ? tiny : edge_zero;

	always_comb begin
		nreq.start  = (st_q == S_NGO) && !skip_job;
		nreq.frac14 = is_vertex;
		if (is_vertex) begin
			nreq.a = sx;
			nreq.b = sy;
		end else if (!tot_q[63]) begin
			// non-negative winding: (-dy, dx)
			nreq.a = -NIN_W'(dy);
			nreq.b = NIN_W'(dx);
		end else begin
			nreq.a = NIN_W'(dy);
			nreq.b = -NIN_W'(dx);
		end
	end

	cinq_norm u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (nreq),
		.rsp   (nrsp)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
			area_q  <= '0;
			job_q   <= JOB_E0;
			beat_q  <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_APPEND: begin
								if (count_q < CW'(MAX_POINTS)) begin
									count_q <= count_q + CW'(1);
									if (count_q != '0) begin
										st_q <= S_A1;
									end
								end
							end
							MODE_CLEAR: begin
								count_q <= '0;
								area_q  <= '0;
							end
							MODE_EMIT: begin
								if (emit_ok) begin
									st_q <= S_R0;
								end
							end
							default: ;
						endcase
					end
				end
				S_A1: st_q <= S_A2;
				S_A2: begin
					area_q <= area_q + 64'(mul_q);
					st_q   <= S_A3;
				end
				S_A3: begin
					area_q <= area_q - 64'(mul_q);
					st_q   <= S_IDLE;
				end
				S_R0: st_q <= S_R1;
				S_R1: st_q <= rd_keep ? S_R2 : S_IDLE;
				S_R2: st_q <= S_R3;
				S_R3: st_q <= S_R4;
				S_R4: st_q <= S_W1;
				S_W1: st_q <= S_W2;
				S_W2: begin
					job_q <= JOB_E0;
					st_q  <= S_NGO;
				end
				S_NGO: begin
					if (skip_job) begin
						job_q <= job_q + 3'd1;
						if (job_q == JOB_VJ) begin
							beat_q <= '0;
							st_q   <= S_OUT;
						end
					end else begin
						st_q <= S_NWT;
					end
				end
				S_NWT: begin
					if (nrsp.done) begin
						job_q <= job_q + 3'd1;
						if (job_q == JOB_VJ) begin
							beat_q <= '0;
							st_q   <= S_OUT;
						end else begin
							st_q <= S_NGO;
						end
					end
				end
				S_OUT: begin
					beat_q <= beat_q + 3'd1;
					if (beat_q == 3'd5) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// points, winding total and normal results
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_EMIT) begin
			i_q <= AW'(edge_index);
		end
		if (ram_we) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
			if (count_q == '0) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
				last_x_q  <= in_x;
				last_y_q  <= in_y;
			end
		end
		case (st_q)
			S_A3: begin
				last_x_q <= cur_x_q;
				last_y_q <= cur_y_q;
			end
			S_R1: begin pi_x_q <= rd_x; pi_y_q <= rd_y; end
			S_R2: begin pm_x_q <= rd_x; pm_y_q <= rd_y; end
			S_R3: begin pj_x_q <= rd_x; pj_y_q <= rd_y; end
			S_R4: begin pk_x_q <= rd_x; pk_y_q <= rd_y; end
			S_W1: tot_q <= area_q + 64'(mul_q);
			S_W2: tot_q <= tot_q - 64'(mul_q);
			S_NGO: begin
				if (skip_job) begin
					case (job_q)
						JOB_E0: begin ev_q[0] <= 1'b0; ex_q[0] <= '0; ey_q[0] <= '0; end
						JOB_E1: begin ev_q[1] <= 1'b0; ex_q[1] <= '0; ey_q[1] <= '0; end
						JOB_E2: begin ev_q[2] <= 1'b0; ex_q[2] <= '0; ey_q[2] <= '0; end
						JOB_VI: begin nxi_q <= '0; nyi_q <= '0; end
						default: begin nxj_q <= '0; nyj_q <= '0; end
					endcase
				end
			end
			S_NWT: begin
				if (nrsp.done) begin
					case (job_q)
						JOB_E0: begin ev_q[0] <= 1'b1; ex_q[0] <= nrsp.oa; ey_q[0] <= nrsp.ob; end
						JOB_E1: begin ev_q[1] <= 1'b1; ex_q[1] <= nrsp.oa; ey_q[1] <= nrsp.ob; end
						JOB_E2: begin ev_q[2] <= 1'b1; ex_q[2] <= nrsp.oa; ey_q[2] <= nrsp.ob; end
						JOB_VI: begin nxi_q <= nrsp.oa[15:0]; nyi_q <= nrsp.ob[15:0]; end
						default: begin nxj_q <= nrsp.oa[15:0]; nyj_q <= nrsp.ob[15:0]; end
					endcase
				end
			end
			default: ;
		endcase
	end

	// vertex beats: registered in the cycle after their sequencer step
	assign use_j  = BEAT_USE_J[beat_q];
	assign ox_ext = EXT'(use_j ? pj_x_q : pi_x_q);
	assign oy_ext = EXT'(use_j ? pj_y_q : pi_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_valid <= 1'b0;
		end else begin
			vert_valid <= (st_q == S_OUT);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_OUT) begin
			vert_x      <= ox_ext[FLD_W-1:0];
			vert_y      <= oy_ext[FLD_W-1:0];
			normal_x    <= use_j ? nxj_q : nxi_q;
			normal_y    <= use_j ? nyj_q : nyi_q;
			ramp        <= BEAT_RAMP[beat_q];
			last_vertex <= (beat_q == 3'd5);
		end
	end

	// the sixth vertex closes the quad: nothing follows it at once
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		vert_valid && last_vertex |=> !vert_valid)
		else $error("vertex strobe right after the last vertex");

	// an append to a full store changes nothing
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_APPEND && count_q == CW'(MAX_POINTS)
		|=> count_q == $past(count_q) && area_q == $past(area_q))
		else $error("append to full store was taken");

	// the normaliser only reports while the sequencer waits for it
	a_norm_wait: assert property (@(posedge clk) disable iff (!arst_n)
		nrsp.done |-> st_q == S_NWT)
		else $error("normaliser result outside its wait step");

	// a strobe only follows an output step
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		vert_valid |-> $past(st_q) == S_OUT)
		else $error("vertex strobe without output step");

endmodule

// ===== sim/tb_contour_inward_normal_quads.sv =====
// testbench for the contour inward normal quad emitter
`timescale 1ns / 100ps

module tb_contour_inward_normal_quads;
	import cinq_pkg::*;

	localparam int          NPTS      = 1024;
	localparam logic [1:0]  MODE_NONE = 2'd3;  // unused code, must do nothing
	localparam int          TAIL      = 1200;  // one emit's worth of cycles

	typedef struct {
		logic [23:0] x;
		logic [23:0] y;
		logic [15:0] nx;
		logic [15:0] ny;
		logic        rmp;
		logic        last;
	} vertex_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              mode;
	logic signed [FLD_W-1:0] point_x;
	logic signed [FLD_W-1:0] point_y;
	logic                    keep_edge;
	logic [IDX_W-1:0]        edge_index;
	logic                    vert_valid;
	logic signed [FLD_W-1:0] vert_x;
	logic signed [FLD_W-1:0] vert_y;
	logic signed [15:0]      normal_x;
	logic signed [15:0]      normal_y;
	logic                    ramp;
	logic                    last_vertex;

	// shadow of the contour held by the block
	longint      shadow_x [NPTS];
	longint      shadow_y [NPTS];
	bit          shadow_keep [NPTS];
	int          shadow_count;
	bit [63:0]   shadow_area;

	vertex_t     pending_verts [$];
	int          mismatches;
	int          idle_pct;

	contour_inward_normal_quads u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.point_x    (point_x),
		.point_y    (point_y),
		.keep_edge  (keep_edge),
		.edge_index (edge_index),
		.vert_valid (vert_valid),
		.vert_x     (vert_x),
		.vert_y     (vert_y),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.ramp       (ramp),
		.last_vertex(last_vertex)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous cap on the simulated time
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

	// floor square root, digit by digit
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned magnitude(input longint a);
		return (a < 0) ? longint'(-a) : longint'(a);
	endfunction

	// scale to unit length with f fraction bits, rounding half up, clamped to one
	task automatic unit_scale(input longint a, input longint b, input int f,
			output longint oa, output longint ob);
		longint unsigned ma, mb, mx, r, qa, qb, one;
		ma = magnitude(a);
		mb = magnitude(b);
		mx = (ma > mb) ? ma : mb;
		while (mx < (64'd1 << 28)) begin
			ma <<= 1; mb <<= 1; mx <<= 1;
		end
		while (mx >= (64'd1 << 29)) begin
			ma >>= 1; mb >>= 1; mx >>= 1;
		end
		r   = root_floor(ma * ma + mb * mb);
		one = 64'd1 << f;
		qa  = ((ma << f) + r / 2) / r;
		qb  = ((mb << f) + r / 2) / r;
		if (qa > one) qa = one;
		if (qb > one) qb = one;
		oa = (a < 0) ? -longint'(qa) : longint'(qa);
		ob = (b < 0) ? -longint'(qb) : longint'(qb);
	endtask

	// winding-signed Q2.30 normal of edge ia->ib, zero-length edges give none
	task automatic edge_normal_q30(input int ia, input int ib, input longint sgn,
			output bit ok, output longint nx, output longint ny);
		longint dx, dy;
		dx = shadow_x[ib] - shadow_x[ia];
		dy = shadow_y[ib] - shadow_y[ia];
		nx = 0;
		ny = 0;
		ok = !(dx == 0 && dy == 0);
		if (ok) unit_scale(-dy * sgn, dx * sgn, 30, nx, ny);
	endtask

	task automatic point_normal(input int i, input int n, input longint sgn,
			output longint nx, output longint ny);
		bit     ok_in, ok_out;
		longint ax, ay, bx, by, sx, sy;
		longint unsigned l2;
		edge_normal_q30((i + n - 1) % n, i, sgn, ok_in, ax, ay);
		edge_normal_q30(i, (i + 1) % n, sgn, ok_out, bx, by);
		if (ok_in && ok_out) begin
			sx = ax + bx; sy = ay + by;
		end else if (ok_out) begin
			sx = bx; sy = by;
		end else begin
			sx = ax; sy = ay;
		end
		l2 = magnitude(sx) * magnitude(sx) + magnitude(sy) * magnitude(sy);
		nx = 0;
		ny = 0;
		// a near-cancelled sum gives a zero normal
		if (l2 >= 2) unit_scale(sx, sy, 14, nx, ny);
	endtask

	function automatic bit [63:0] cross_of(input int p, input int q);
		return 64'(shadow_x[p] * shadow_y[q] - shadow_x[q] * shadow_y[p]);
	endfunction

	// update the shadow contour and queue the quad that an item causes
	task automatic predict_item(input logic [1:0] m, input logic [23:0] x,
			input logic [23:0] y, input logic k, input logic [9:0] idx);
		int        n, i, j, p;
		bit [63:0] total;
		longint    sgn, nxi, nyi, nxj, nyj;
		vertex_t   v;
		case (m)
			MODE_APPEND: begin
				// a full store drops the point
				if (shadow_count < NPTS) begin
					shadow_x[shadow_count]    = longint'($signed(x));
					shadow_y[shadow_count]    = longint'($signed(y));
					shadow_keep[shadow_count] = k;
					if (shadow_count > 0)
						shadow_area += cross_of(shadow_count - 1, shadow_count);
					shadow_count++;
				end
			end
			MODE_CLEAR: begin
				shadow_count = 0;
				shadow_area  = 0;
			end
			MODE_EMIT: begin
				n = shadow_count;
				i = idx;
				// refused: short contour, index past the end, or edge not kept
				if (n >= 3 && i < n && shadow_keep[i]) begin
					j     = (i + 1) % n;
					total = shadow_area + cross_of(n - 1, 0);
					sgn   = total[63] ? -1 : 1;
					point_normal(i, n, sgn, nxi, nyi);
					point_normal(j, n, sgn, nxj, nyj);
					for (int b = 0; b < 6; b++) begin
						p      = BEAT_USE_J[b] ? j : i;
						v.x    = shadow_x[p][23:0];
						v.y    = shadow_y[p][23:0];
						v.nx   = BEAT_USE_J[b] ? nxj[15:0] : nxi[15:0];
						v.ny   = BEAT_USE_J[b] ? nyj[15:0] : nyi[15:0];
						v.rmp  = BEAT_RAMP[b];
						v.last = (b == 5);
						pending_verts.insert(pending_verts.size(), v);
					end
				end
			end
			default: ;
		endcase
	endtask

	// present one item, hold it until taken, then maybe leave a gap
	task automatic send_item(input logic [1:0] m, input logic [23:0] x,
			input logic [23:0] y, input logic k, input logic [9:0] idx);
		start      <= 1'b1;
		mode       <= m;
		point_x    <= x;
		point_y    <= y;
		keep_edge  <= k;
		edge_index <= idx;
		do @(posedge clk); while (busy);
		predict_item(m, x, y, k, idx);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic add_point(input logic [23:0] x, input logic [23:0] y, input logic k);
		send_item(MODE_APPEND, x, y, k, 10'($urandom));
	endtask

	task automatic emit_edge(input logic [9:0] idx);
		send_item(MODE_EMIT, 24'($urandom), 24'($urandom), 1'($urandom), idx);
	endtask

	task automatic clear_contour();
		send_item(MODE_CLEAR, 24'($urandom), 24'($urandom), 1'($urandom),
			10'($urandom));
	endtask

	// check one field of a vertex
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// every strobed vertex is compared with the oldest queued one
	always @(posedge clk) begin
		vertex_t v;
		if (arst_n && vert_valid) begin
			if (pending_verts.size() == 0) begin
				$display("%0t: vertex with none expected, expected none actual %h %h",
					$time, vert_x, vert_y);
				mismatches++;
			end else begin
				v = pending_verts.pop_front();
				check_field("vert_x", v.x, $unsigned(vert_x));
				check_field("vert_y", v.y, $unsigned(vert_y));
				check_field("normal_x", v.nx, $unsigned(normal_x));
				check_field("normal_y", v.ny, $unsigned(normal_y));
				check_field("ramp", v.rmp, ramp);
				check_field("last_vertex", v.last, last_vertex);
			end
		end
	end

	// short contours, bad indices, skipped edges and the unused code
	task automatic test_refusals();
		clear_contour();
		emit_edge(10'd0);
		add_point(24'sd0, 24'sd0, 1'b1);
		add_point(24'sd100, 24'sd0, 1'b1);
		emit_edge(10'd0);
		add_point(24'sd0, 24'sd100, 1'b0);
		emit_edge(10'd3);
		emit_edge(10'h3ff);
		emit_edge(10'd2);
		send_item(MODE_NONE, 24'hffffff, 24'hffffff, 1'b1, 10'd0);
	endtask

	// counter-clockwise and clockwise triangles at the coordinate extremes
	task automatic test_extremes();
		clear_contour();
		add_point(24'h800000, 24'h800000, 1'b1);
		add_point(24'h7fffff, 24'h800000, 1'b1);
		add_point(24'h000000, 24'h7fffff, 1'b1);
		for (int e = 0; e < 3; e++) emit_edge(10'(e));
		clear_contour();
		add_point(24'h7fffff, 24'h7fffff, 1'b1);
		add_point(24'h7fffff, 24'h800000, 1'b1);
		add_point(24'h800000, 24'h800000, 1'b1);
		emit_edge(10'd2);
	endtask

	// repeated points and a spike whose edge normals cancel
	task automatic test_degenerate();
		clear_contour();
		add_point(24'sd5, 24'sd5, 1'b1);
		add_point(24'sd5, 24'sd5, 1'b1);
		add_point(24'sd50, 24'sd5, 1'b1);
		add_point(24'sd5, 24'sd60, 1'b1);
		emit_edge(10'd0);
		clear_contour();
		for (int k = 0; k < 3; k++) add_point(-24'sd7, 24'sd9, 1'b1);
		emit_edge(10'd1);
		clear_contour();
		add_point(24'sd0, 24'sd0, 1'b1);
		add_point(24'sd1000, 24'sd0, 1'b1);
		add_point(24'sd0, 24'sd0, 1'b1);
		emit_edge(10'd1);
	endtask

	function automatic logic [23:0] rand_coord();
		if ($urandom_range(1)) return 24'($urandom);
		return 24'($urandom_range(0, 128)) - 24'd64;
	endfunction

	// mostly well-formed contours with random content, some noise
	task automatic test_random(input int items);
		int n, sent;
		logic [23:0] lx, ly;
		sent = 0;
		while (sent < items) begin
			clear_contour();
			n = $urandom_range(3, 8);
			for (int k = 0; k < n; k++) begin
				if (k > 0 && $urandom_range(9) == 0) begin
					// repeat the last point for a zero-length edge
				end else begin
					lx = rand_coord();
					ly = rand_coord();
				end
				add_point(lx, ly, $urandom_range(3) != 0);
			end
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(4) == 0) emit_edge(10'($urandom));
				else emit_edge(10'($urandom_range(0, n - 1)));
			end
			if ($urandom_range(19) == 0)
				send_item(MODE_NONE, 24'($urandom), 24'($urandom), 1'($urandom),
					10'($urandom));
			sent += n + 4;
		end
	endtask

	initial begin
		int waited;
		mismatches = 0;
		idle_pct   = 6;
		shadow_count = 0;
		shadow_area  = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		mode       = MODE_APPEND;
		point_x    = '0;
		point_y    = '0;
		keep_edge  = 1'b0;
		edge_index = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_refusals();
		test_extremes();
		test_degenerate();
		test_random(28);
		idle_pct = 76;
		test_random(28);
		idle_pct = 0;
		test_random(28);
		start <= 1'b0;

		// drain: the last vertices, then one emit's worth of quiet
		waited = 0;
		while (pending_verts.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && pending_verts.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== contour_inward_normal_quads.f =====
design/cinq_pkg.sv
design/cinq_ram.sv
design/cinq_norm.sv
design/contour_inward_normal_quads.sv
sim/tb_contour_inward_normal_quads.sv
